[rtl/core/kcdj_pkg.sv]
// kcdj_pkg: shared types, constants and helpers for the kinematic car derivative core
// no dependencies; used by kcdj_cordic, kcdj_div and the top level under rtl/core
`default_nettype none

package kcdj_pkg;

  typedef logic [31:0] kcdj_word_t;

  localparam int KCDJ_CORDIC_STEPS = 28;
  // quotient bits produced by the divider, one more than the result for overflow
  localparam int KCDJ_QUO_W        = 33;
  // divider pipeline depth: magnitude stage, setup stage, one stage per quotient bit, result stage
  localparam int KCDJ_DIV_LAT      = KCDJ_QUO_W + 3;

  localparam logic signed [32:0] KCDJ_GAIN    = 33'sd652032874;
  localparam logic signed [33:0] KCDJ_PI      = 34'sd3373259426;
  localparam logic signed [33:0] KCDJ_HALF_PI = 34'sd1686629713;

  localparam logic [31:0] KCDJ_ATAN [0:KCDJ_CORDIC_STEPS-1] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008
  };

  localparam kcdj_word_t KCDJ_S32_MAX = 32'h7FFF_FFFF;
  localparam kcdj_word_t KCDJ_S32_MIN = 32'h8000_0000;

  // clamp to the signed 32-bit range
  function automatic kcdj_word_t kcdj_sat32(input logic signed [63:0] v);
    kcdj_word_t res;
    if (v > 64'sd2147483647) begin
      res = KCDJ_S32_MAX;
    end else if (v < -64'sd2147483648) begin
      res = KCDJ_S32_MIN;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // shift down with round half up, then clamp
  function automatic kcdj_word_t kcdj_rnd_sat(input logic signed [63:0] v, input int sh);
    logic signed [63:0] t;
    t = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    return kcdj_sat32(t);
  endfunction

endpackage

`default_nettype wire

[rtl/core/kcdj_cordic.sv]
// kcdj_cordic: two-lane pipelined rotation cordic, one stage per step, sine and cosine in Q30
// depends on kcdj_pkg (step count, gain, pi, arctangent table)
`default_nettype none

module kcdj_cordic #(
  parameter int SIDE_W = 48
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [15:0]       ang_a,
  input  logic signed [15:0]       ang_b,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output logic signed [31:0]       sin_a,
  output logic signed [31:0]       cos_a,
  output logic signed [31:0]       sin_b,
  output logic signed [31:0]       cos_b,
  output logic [SIDE_W-1:0]        out_side
);
  import kcdj_pkg::*;

  localparam int NS = KCDJ_CORDIC_STEPS;
  localparam int XW = 33;
  localparam int ZW = 34;

  logic [NS:0]              v_r;
  logic [SIDE_W-1:0]        side_r [0:NS];
  logic signed [XW-1:0]     x_r    [0:1][0:NS];
  logic signed [XW-1:0]     y_r    [0:1][0:NS];
  logic signed [ZW-1:0]     z_r    [0:1][0:NS];
  logic                     flip_r [0:1][0:NS];
  logic signed [15:0]       ang    [0:1];
  logic signed [XW-1:0]     xo     [0:1];
  logic signed [XW-1:0]     yo     [0:1];

  assign ang[0] = ang_a;
  assign ang[1] = ang_b;

  // valid bits and side payload travel with the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
    end
  end

  genvar l, i;
  generate
    for (i = 0; i < NS; i++) begin : g_side
      always_ff @(posedge clk) begin
        if (en) begin
          side_r[i+1] <= side_r[i];
        end
      end
    end

    for (l = 0; l < 2; l++) begin : g_lane
      logic signed [ZW-1:0] z_in;
      assign z_in = $signed({ang[l][15], ang[l], 17'b0});

      // fold the angle into plus or minus half pi
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[l][0] <= KCDJ_GAIN;
          y_r[l][0] <= '0;
          if (z_in > KCDJ_HALF_PI) begin
            z_r[l][0]    <= z_in - KCDJ_PI;
            flip_r[l][0] <= 1'b1;
          end else if (z_in < -KCDJ_HALF_PI) begin
            z_r[l][0]    <= z_in + KCDJ_PI;
            flip_r[l][0] <= 1'b1;
          end else begin
            z_r[l][0]    <= z_in;
            flip_r[l][0] <= 1'b0;
          end
        end
      end

      for (i = 0; i < NS; i++) begin : g_step
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [ZW-1:0] at;
        assign xs = x_r[l][i] >>> i;
        assign ys = y_r[l][i] >>> i;
        assign at = $signed({2'b0, KCDJ_ATAN[i]});

        // one micro-rotation
        always_ff @(posedge clk) begin
          if (en) begin
            flip_r[l][i+1] <= flip_r[l][i];
            if (!z_r[l][i][ZW-1]) begin
              x_r[l][i+1] <= x_r[l][i] - ys;
              y_r[l][i+1] <= y_r[l][i] + xs;
              z_r[l][i+1] <= z_r[l][i] - at;
            end else begin
              x_r[l][i+1] <= x_r[l][i] + ys;
              y_r[l][i+1] <= y_r[l][i] - xs;
              z_r[l][i+1] <= z_r[l][i] + at;
            end
          end
        end
      end

      // undo the fold
      assign xo[l] = flip_r[l][NS] ? -x_r[l][NS] : x_r[l][NS];
      assign yo[l] = flip_r[l][NS] ? -y_r[l][NS] : y_r[l][NS];
    end
  endgenerate

  assign out_valid = v_r[NS];
  assign out_side  = side_r[NS];
  assign cos_a     = xo[0][31:0];
  assign sin_a     = yo[0][31:0];
  assign cos_b     = xo[1][31:0];
  assign sin_b     = yo[1][31:0];

endmodule

`default_nettype wire

[rtl/core/kcdj_div.sv]
// kcdj_div: pipelined restoring divider, quotient rounded to nearest (ties away), Q16.16 clamp
// depends on kcdj_pkg (quotient width, saturation limits)
`default_nettype none

module kcdj_div #(
  parameter int NW = 64,
  parameter int DW = 49
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic signed [31:0]   quo
);
  import kcdj_pkg::*;

  localparam int QB = KCDJ_QUO_W;
  localparam int RW = (NW + 1 > DW + 1 + QB) ? NW + 1 : DW + 1 + QB;

  typedef struct packed {
    logic nz;
    logic dz;
    logic neg;
    logic ovf;
  } div_flags_t;

  logic [NW-1:0]   an_r;
  logic [DW-1:0]   ad_r;
  logic            neg_r;
  logic [RW-1:0]   n_b;
  logic [RW-1:0]   dq_b;
  logic [RW-1:0]   r_r  [0:QB];
  logic [DW:0]     d_r  [0:QB];
  logic [QB-1:0]   q_r  [0:QB];
  div_flags_t      fl_r [0:QB];
  logic [QB-1:0]   q_fin;
  div_flags_t      fl_fin;
  kcdj_word_t      quo_nxt;
  kcdj_word_t      quo_r;

  // magnitudes and result sign
  always_ff @(posedge clk) begin
    if (en) begin
      an_r  <= num[NW-1] ? NW'(-num) : NW'(num);
      ad_r  <= den[DW-1] ? DW'(-den) : DW'(den);
      neg_r <= num[NW-1] ^ den[DW-1];
    end
  end

  // rounding numerator 2n+d over 2d, overflow when the quotient needs more bits
  assign n_b  = (RW'(an_r) << 1) + RW'(ad_r);
  assign dq_b = RW'({ad_r, 1'b0}) << QB;

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]  <= n_b;
      d_r[0]  <= {ad_r, 1'b0};
      q_r[0]  <= '0;
      fl_r[0] <= '{nz: |an_r, dz: |ad_r, neg: neg_r, ovf: (n_b >= dq_b)};
    end
  end

  genvar j;
  generate
    for (j = 0; j < QB; j++) begin : g_bit
      logic [RW-1:0] dsh;
      logic          ge;
      assign dsh = RW'(d_r[j]) << (QB - 1 - j);
      assign ge  = (r_r[j] >= dsh);

      // one quotient bit
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[j+1]  <= ge ? (r_r[j] - dsh) : r_r[j];
          d_r[j+1]  <= d_r[j];
          q_r[j+1]  <= {q_r[j][QB-2:0], ge};
          fl_r[j+1] <= fl_r[j];
        end
      end
    end
  endgenerate

  assign q_fin  = q_r[QB];
  assign fl_fin = fl_r[QB];

  // special cases, sign and clamp
  always_comb begin
    if (!fl_fin.nz) begin
      quo_nxt = '0;
    end else if (!fl_fin.dz || fl_fin.ovf) begin
      quo_nxt = fl_fin.neg ? KCDJ_S32_MIN : KCDJ_S32_MAX;
    end else if (fl_fin.neg) begin
      quo_nxt = (q_fin > 33'd2147483648) ? KCDJ_S32_MIN : (~q_fin[31:0] + 32'd1);
    end else begin
      quo_nxt = (q_fin > 33'd2147483647) ? KCDJ_S32_MAX : q_fin[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

`default_nettype wire

[rtl/core/kcdj_skid.sv]
// kcdj_skid: output register with a one-beat skid stage, registered ready towards the pipeline
// no package dependencies
`default_nettype none

module kcdj_skid #(
  parameter int WIDTH = 352
) (
  input  logic             clk,
  input  logic             rst_n,
  output logic             en,
  input  logic             s_valid,
  input  logic [WIDTH-1:0] s_data,
  output logic             m_valid,
  input  logic             m_ready,
  output logic [WIDTH-1:0] m_data
);

  logic             full_r;
  logic [WIDTH-1:0] skid_r;
  logic             m_valid_r;
  logic [WIDTH-1:0] m_data_r;
  logic             take;
  logic             out_free;

  assign en       = !full_r;
  assign take     = en && s_valid;
  assign out_free = !m_valid_r || m_ready;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      full_r    <= 1'b0;
    end else if (out_free) begin
      if (full_r) begin
        m_valid_r <= 1'b1;
        full_r    <= 1'b0;
      end else begin
        m_valid_r <= take;
      end
    end else if (take) begin
      full_r <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (full_r) begin
        m_data_r <= skid_r;
      end else if (take) begin
        m_data_r <= s_data;
      end
    end else if (take) begin
      skid_r <= s_data;
    end
  end

  assign m_valid = m_valid_r;
  assign m_data  = m_data_r;

endmodule

`default_nettype wire

[rtl/core/kinematic_car_derivative_jacobian_core.sv]
// kinematic_car_derivative_jacobian_core: top level, state derivatives and Jacobian of a car
// depends on kcdj_pkg, kcdj_cordic, kcdj_div and kcdj_skid
`default_nettype none

// Takes one beat per clock cycle while in_tready is high and delivers one result beat
// per input beat, in order. A beat passes through the two-lane cordic (angle fold plus
// 28 steps), the product stages, the three parallel dividers (one quotient bit per
// stage) and the output register. The whole pipeline moves together; in_tready is
// registered and falls only while the skid stage behind the output register holds a
// beat. Wheelbase is read directly by the product stages, so write cfg_wr_en only while
// no beat is in flight.
module kinematic_car_derivative_jacobian_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // heading[15:0], steer_angle[30:16], speed[46:31], steer_rate[62:47], accel[78:63], pad
  input  logic [79:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // dx, dy, dheading, dsteer, dspeed, jac_x_heading, jac_x_speed, jac_y_heading,
  // jac_y_speed, jac_heading_steer, jac_heading_speed; 32 bits each from bit 0 up
  output logic [351:0] out_tdata
);
  import kcdj_pkg::*;

  localparam int DL = KCDJ_DIV_LAT;

  logic               en;
  logic [15:0]        wheelbase_r;
  logic signed [16:0] wb_s;

  logic               c_valid;
  logic signed [31:0] c_st, c_ct, c_sp, c_cp;
  logic [47:0]        c_side;
  logic signed [15:0] c_v, c_om, c_a;

  logic               p1_valid_r;
  logic signed [47:0] p1_vct_r, p1_vst_r, p1_vsp_r;
  logic signed [48:0] p1_lcp_r;
  logic signed [63:0] p1_cpcp_r;
  logic signed [31:0] p1_st_r, p1_ct_r, p1_sp_r;
  logic signed [15:0] p1_v_r, p1_om_r, p1_a_r;

  logic               p2_valid_r;
  logic [6:0][31:0]   p2_out_r;
  logic signed [33:0] p2_c2_r;
  logic signed [15:0] p2_v_r;
  logic signed [63:0] p2_num1_r;
  logic signed [48:0] p2_den1_r;
  logic signed [55:0] p2_num3_r;
  logic [63:0]        cpcp_rnd;

  logic               p3_valid_r;
  logic [6:0][31:0]   p3_out_r;
  logic signed [63:0] p3_num1_r;
  logic signed [48:0] p3_den1_r;
  logic signed [61:0] p3_num2_r;
  logic signed [50:0] p3_den2_r;
  logic signed [55:0] p3_num3_r;

  logic [DL-1:0]          dly_valid_r;
  logic [DL-1:0][6:0][31:0] dly_out_r;
  logic signed [31:0]     q_dh, q_jhst, q_jhsp;
  logic [6:0][31:0]       fin;
  logic [351:0]           res_data;

  // wheelbase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheelbase_r <= 16'd768;
    end else if (cfg_wr_en) begin
      wheelbase_r <= cfg_wr_data;
    end
  end

  assign wb_s = $signed({1'b0, wheelbase_r});

  // sine and cosine of heading and steering angle
  kcdj_cordic #(.SIDE_W(48)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .ang_a     ($signed(in_tdata[15:0])),
    .ang_b     ($signed({in_tdata[30], in_tdata[30:16]})),
    .in_side   (in_tdata[78:31]),
    .out_valid (c_valid),
    .sin_a     (c_st),
    .cos_a     (c_ct),
    .sin_b     (c_sp),
    .cos_b     (c_cp),
    .out_side  (c_side)
  );

  assign c_v  = $signed(c_side[15:0]);
  assign c_om = $signed(c_side[31:16]);
  assign c_a  = $signed(c_side[47:32]);

  // products stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_vct_r  <= c_v * c_ct;
      p1_vst_r  <= c_v * c_st;
      p1_vsp_r  <= c_v * c_sp;
      p1_lcp_r  <= wb_s * c_cp;
      p1_cpcp_r <= c_cp * c_cp;
      p1_st_r   <= c_st;
      p1_ct_r   <= c_ct;
      p1_sp_r   <= c_sp;
      p1_v_r    <= c_v;
      p1_om_r   <= c_om;
      p1_a_r    <= c_a;
    end
  end

  // rounding of the direct outputs, cos squared, division operands
  assign cpcp_rnd = p1_cpcp_r + 64'sd536870912;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else if (en) begin
      p2_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_out_r[0] <= kcdj_rnd_sat(64'(p1_vct_r), 22);
      p2_out_r[1] <= kcdj_rnd_sat(64'(p1_vst_r), 22);
      p2_out_r[2] <= {{8{p1_om_r[15]}}, p1_om_r, 8'b0};
      p2_out_r[3] <= {{8{p1_a_r[15]}}, p1_a_r, 8'b0};
      p2_out_r[4] <= kcdj_rnd_sat(-64'(p1_vst_r), 22);
      p2_out_r[5] <= kcdj_rnd_sat(64'(p1_ct_r), 14);
      p2_out_r[6] <= kcdj_rnd_sat(64'(p1_st_r), 14);
      p2_c2_r     <= $signed(cpcp_rnd[63:30]);
      p2_v_r      <= p1_v_r;
      p2_num1_r   <= $signed({p1_vsp_r, 16'b0});
      p2_den1_r   <= p1_lcp_r;
      p2_num3_r   <= $signed({p1_sp_r, 24'b0});
    end
  end

  // wheelbase times cos squared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_valid_r <= 1'b0;
    end else if (en) begin
      p3_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_out_r  <= p2_out_r;
      p3_num1_r <= p2_num1_r;
      p3_den1_r <= p2_den1_r;
      p3_num2_r <= $signed({p2_v_r, 46'b0});
      p3_den2_r <= wb_s * p2_c2_r;
      p3_num3_r <= p2_num3_r;
    end
  end

  // three quotients in parallel
  kcdj_div #(.NW(64), .DW(49)) u_div_dh (
    .clk (clk), .en (en), .num (p3_num1_r), .den (p3_den1_r), .quo (q_dh)
  );

  kcdj_div #(.NW(62), .DW(51)) u_div_jhst (
    .clk (clk), .en (en), .num (p3_num2_r), .den (p3_den2_r), .quo (q_jhst)
  );

  kcdj_div #(.NW(56), .DW(49)) u_div_jhsp (
    .clk (clk), .en (en), .num (p3_num3_r), .den (p3_den1_r), .quo (q_jhsp)
  );

  // direct outputs and valid bits run alongside the dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_valid_r <= '0;
    end else if (en) begin
      dly_valid_r <= {dly_valid_r[DL-2:0], p3_valid_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly_out_r <= {dly_out_r[DL-2:0], p3_out_r};
    end
  end

  assign fin = dly_out_r[DL-1];

  assign res_data = {q_jhsp, q_jhst, fin[6], fin[0], fin[5], fin[4],
                     fin[3], fin[2], q_dh, fin[1], fin[0]};

  // output register and skid
  kcdj_skid #(.WIDTH(352)) u_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .s_valid (dly_valid_r[DL-1]),
    .s_data  (res_data),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (out_tdata)
  );

  assign in_tready = en;

endmodule

`default_nettype wire

[tb/kinematic_car_derivative_jacobian_core_test.sv]
// testbench for kinematic_car_derivative_jacobian_core: random and directed beats checked
// against a bit-exact predictor held in a small scoreboard class; depends on the core only
`timescale 1ns / 1ps

module kinematic_car_derivative_jacobian_core_test;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 100;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30    = 64'sd652032874;

  // one input beat
  typedef struct {
    logic signed [15:0] heading;
    logic signed [14:0] steer_angle;
    logic signed [15:0] speed;
    logic signed [15:0] steer_rate;
    logic signed [15:0] accel;
  } car_sample_t;

  // derivative and jacobian predictor with its expected-beat queue
  class derivative_scoreboard;
    logic [15:0]  wheelbase;
    logic [351:0] pending_results[$];
    int           errors;
    longint       atan_q30[28];

    function new();
      wheelbase = 16'd768;
      errors = 0;
      atan_q30 = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
        'h0000003F, 'h0000001F, 'h0000000F, 'h00000008};
    endfunction

    function logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function longint round_down(longint v, int sh);
      return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    // nearest, ties away from zero; zero divisor saturates to numerator sign
    function logic [31:0] quotient_sat(longint num, longint den);
      bit neg;
      longint unsigned an, ad, q;
      neg = (num < 0) != (den < 0);
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      if (an == 0) return 32'd0;
      if (ad == 0) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      q = (2 * an + ad) / (2 * ad);
      if (neg) return q > 64'd2147483648 ? 32'h8000_0000 : clamp32(-longint'(q));
      return q > 64'd2147483647 ? 32'h7FFF_FFFF : clamp32(longint'(q));
    endfunction

    // q3.13 angle to q30 sine and cosine, folded into plus or minus half pi
    function void angle_sincos(longint ang, output longint s, output longint c);
      longint z, x, y, nx;
      bit flip;
      z = ang * 131072;
      x = GAIN_Q30;
      y = 0;
      flip = 0;
      if (z > HALF_PI_Q30) begin
        z -= PI_Q30;
        flip = 1;
      end else if (z < -HALF_PI_Q30) begin
        z += PI_Q30;
        flip = 1;
      end
      for (int i = 0; i < 28; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= atan_q30[i];
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += atan_q30[i];
        end
        x = nx;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    function void note_sample(car_sample_t smp);
      longint th, ph, v, om, a, wb, st, ct, sp, cp, c2;
      logic [351:0] r;
      th = smp.heading;
      ph = smp.steer_angle;
      v = smp.speed;
      om = smp.steer_rate;
      a = smp.accel;
      wb = wheelbase;
      angle_sincos(th, st, ct);
      angle_sincos(ph, sp, cp);
      c2 = round_down(cp * cp, 30);
      r[0*32 +: 32]  = clamp32(round_down(v * ct, 22));
      r[1*32 +: 32]  = clamp32(round_down(v * st, 22));
      r[2*32 +: 32]  = quotient_sat(v * sp * 65536, wb * cp);
      r[3*32 +: 32]  = clamp32(om * 256);
      r[4*32 +: 32]  = clamp32(a * 256);
      r[5*32 +: 32]  = clamp32(round_down(-(v * st), 22));
      r[6*32 +: 32]  = clamp32(round_down(ct, 14));
      r[7*32 +: 32]  = clamp32(round_down(v * ct, 22));
      r[8*32 +: 32]  = clamp32(round_down(st, 14));
      r[9*32 +: 32]  = quotient_sat(v * (64'sd1 <<< 46), wb * c2);
      r[10*32 +: 32] = quotient_sat(sp * 16777216, wb * cp);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [351:0] got);
      logic [351:0] want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      for (int f = 0; f < 11; f++) begin
        if (got[f*32 +: 32] !== want[f*32 +: 32]) begin
          $display("%0t: field %0d expected %h actual %h", $time, f,
                   want[f*32 +: 32], got[f*32 +: 32]);
          errors++;
        end
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         cfg_wr_en = 0;
  logic [15:0]  cfg_wr_data = '0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [79:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [351:0] out_tdata;

  derivative_scoreboard sb = new();
  bit quiet = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  kinematic_car_derivative_jacobian_core u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // beat monitor and watchdog
  always @(posedge clk) begin
    car_sample_t smp;
    if (rst_n) begin
      idle_cycles++;
      if (in_tvalid && in_tready) begin
        smp.heading = in_tdata[15:0];
        smp.steer_angle = in_tdata[30:16];
        smp.speed = in_tdata[46:31];
        smp.steer_rate = in_tdata[62:47];
        smp.accel = in_tdata[78:63];
        sb.note_sample(smp);
        idle_cycles = 0;
      end
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
        idle_cycles = 0;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver back-pressure in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready = 0;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_tready = 0;
    end else begin
      out_tready = 1;
    end
  end

  task automatic send_sample(int hd, int sa, int sp, int sr, int ac);
    int gap;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    in_tdata = {1'b0, 16'(ac), 16'(sr), 16'(sp), 15'(sa), 16'(hd)};
    in_tvalid = 1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 0;
  endtask

  task automatic wait_drained();
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_wheelbase(logic [15:0] wb);
    wait_drained();
    cfg_wr_data = wb;
    cfg_wr_en = 1;
    @(negedge clk);
    cfg_wr_en = 0;
    sb.wheelbase = wb;
  endtask

  task automatic send_random(int count);
    for (int k = 0; k < count; k++) begin
      send_sample($urandom_range(0, 51472) - 25736, $urandom_range(0, 24000) - 12000,
                  $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                  $urandom_range(0, 65535) - 32768);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed corners at the reset wheelbase
    send_sample(0, 0, 0, 0, 0);
    send_sample(25736, 12000, 32767, 32767, 32767);
    send_sample(-25736, -12000, -32768, -32768, -32768);
    send_sample(12868, 0, 256, 1, -1);
    send_sample(-12868, 11999, -256, 0, 0);
    send_sample(12869, -11999, 32767, 100, -100);
    send_sample(-12869, 12000, -32768, 0, 0);
    send_sample(8192, 4096, 1, 0, 0);
    send_sample(0, 12000, 0, 0, 0);
    send_sample(25000, -6000, 32767, 0, 0);

    // tiny wheelbase drives the quotients into saturation
    set_wheelbase(16'd1);
    send_sample(0, 12000, 32767, 0, 0);
    send_sample(0, -12000, -32768, 0, 0);
    send_sample(0, 1, 1, 0, 0);
    send_random(150);

    set_wheelbase(16'hFFFF);
    send_sample(0, 12000, 32767, 0, 0);
    send_sample(0, -1, -1, 0, 0);
    send_random(200);

    set_wheelbase(16'd256);
    send_random(200);

    set_wheelbase(16'($urandom_range(1, 65535)));
    send_random(200);

    // last stretch with no idling on either side
    set_wheelbase(16'd768);
    quiet = 1;
    send_random(200);

    wait_drained();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/kcdj_pkg.sv
rtl/core/kcdj_cordic.sv
rtl/core/kcdj_div.sv
rtl/core/kcdj_skid.sv
rtl/core/kinematic_car_derivative_jacobian_core.sv
tb/kinematic_car_derivative_jacobian_core_test.sv
